/* rtl/prdc_pkg.sv */
// Types and constants shared by the PackBits row decoder.
`timescale 1ns / 1ps
`default_nettype none
package prdc_pkg;

   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QPTR_W = $clog2(QDEPTH);
   localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

   localparam int unsigned ROW_W = 15;
   localparam int unsigned REP_W = 17;
   localparam int unsigned LO_W  = 16;

   localparam logic [7:0] HDR_NOP = 8'h80;

   // configuration register indexes
   typedef enum logic {
      REG_ROW_LENGTH = 1'b0,
      REG_NONE       = 1'b1
   } prdc_reg_type;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_REPEAT = 2'd1,
      PH_COPY   = 2'd2,
      PH_DRAIN  = 2'd3
   } prdc_phase_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_END_REPEAT = 3'd1,
      ST_OVERRUN    = 3'd2,
      ST_END_COPY   = 3'd3,
      ST_COPY_FULL  = 3'd4
   } prdc_status_type;

   // one queue entry: an optional run and an optional closing item
   typedef struct packed {
      logic                has_run;
      logic [7:0]          run_byte;
      logic [ROW_W-1:0]    run_count;
      logic                has_final;
      logic [ROW_W-1:0]    final_count;
      prdc_status_type     status;
      logic [REP_W-1:0]    report;
   } prdc_entry_type;

endpackage
`default_nettype wire

/* rtl/prdc_req_if.sv */
// Request channel: packed bytes with the row end flag.
`timescale 1ns / 1ps
`default_nettype none
interface prdc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] packed_byte;
   logic       row_end;

   modport source (output valid, output packed_byte, output row_end, input ready);
   modport sink   (input valid, input packed_byte, input row_end, output ready);
endinterface
`default_nettype wire

/* rtl/prdc_rsp_if.sv */
// Result channel: output runs and the closing item of each row.
`timescale 1ns / 1ps
`default_nettype none
interface prdc_rsp_if;
   logic               valid;
   logic               ready;
   logic [7:0]         out_byte;
   logic [14:0]        run_count;
   logic               is_final;
   logic [2:0]         status;
   logic signed [16:0] report;

   modport source (output valid, output out_byte, output run_count, output is_final,
                   output status, output report, input ready);
   modport sink   (input valid, input out_byte, input run_count, input is_final,
                   input status, input report, output ready);
endinterface
`default_nettype wire

/* rtl/prdc_front.sv */
// Front end: takes packed bytes, tracks the row decode state, builds queue entries.
`timescale 1ns / 1ps
`default_nettype none
module prdc_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   prdc_req_if.sink                        req,
   input  wire logic [prdc_pkg::ROW_W-1:0] row_len,
   input  wire logic                       q_full,
   output      logic                       push,
   output      prdc_pkg::prdc_entry_type   push_data
);

   logic                        row_open_ff, row_open_in;
   prdc_pkg::prdc_phase_type    phase_ff, phase_in;
   logic [7:0]                  pend_ff, pend_in;
   logic [prdc_pkg::ROW_W-1:0]  left_ff, left_in;
   logic [prdc_pkg::LO_W-1:0]   lo_ff, lo_in;
   prdc_pkg::prdc_status_type   err_ff, err_in;

   prdc_pkg::prdc_phase_type    cur_phase;
   logic [7:0]                  cur_pend;
   logic [prdc_pkg::ROW_W-1:0]  cur_left;
   logic [prdc_pkg::LO_W-1:0]   cur_lo;
   prdc_pkg::prdc_status_type   cur_err;

   logic                        has_run;
   logic [prdc_pkg::ROW_W-1:0]  run_cnt;
   logic                        accept;
   logic [7:0]                  b;
   logic                        last;

   assign b         = req.packed_byte;
   assign last      = req.row_end;
   assign req.ready = !q_full;
   assign accept    = req.valid && !q_full;

   // first byte of a row picks up the row length and clears the row state
   always_comb begin
      if (row_open_ff) begin
         cur_phase = phase_ff;
         cur_pend  = pend_ff;
         cur_left  = left_ff;
         cur_lo    = lo_ff;
         cur_err   = err_ff;
      end else begin
         cur_phase = (row_len != '0) ? prdc_pkg::PH_HEADER : prdc_pkg::PH_DRAIN;
         cur_pend  = '0;
         cur_left  = row_len;
         cur_lo    = '0;
         cur_err   = prdc_pkg::ST_OK;
      end
   end

   // next state
   always_comb begin
      logic [prdc_pkg::ROW_W-1:0] left_dec;
      logic [7:0]                 pend_dec;
      left_dec    = (cur_left != '0) ? cur_left - 1'b1 : cur_left;
      pend_dec    = (cur_pend != '0) ? cur_pend - 1'b1 : cur_pend;
      phase_in    = cur_phase;
      pend_in     = cur_pend;
      left_in     = cur_left;
      lo_in       = cur_lo;
      err_in      = cur_err;
      has_run     = 1'b0;
      run_cnt     = '0;
      row_open_in = !last;
      case (cur_phase)
         prdc_pkg::PH_HEADER: begin
            if (b == prdc_pkg::HDR_NOP) begin
               phase_in = prdc_pkg::PH_HEADER;
            end else if (!b[7]) begin
               pend_in  = b + 8'd1;
               phase_in = prdc_pkg::PH_COPY;
               if (last) err_in = prdc_pkg::ST_END_COPY;
            end else begin
               pend_in  = 8'(9'd257 - {1'b0, b});
               phase_in = prdc_pkg::PH_REPEAT;
               if (last) err_in = prdc_pkg::ST_END_REPEAT;
            end
         end
         prdc_pkg::PH_REPEAT: begin
            has_run = 1'b1;
            if ({7'd0, cur_pend} > cur_left) begin
               err_in  = prdc_pkg::ST_OVERRUN;
               run_cnt = cur_left;
            end else begin
               run_cnt = {7'd0, cur_pend};
            end
            left_in  = cur_left - run_cnt;
            pend_in  = '0;
            phase_in = (left_in != '0) ? prdc_pkg::PH_HEADER : prdc_pkg::PH_DRAIN;
         end
         prdc_pkg::PH_COPY: begin
            has_run = 1'b1;
            run_cnt = prdc_pkg::ROW_W'(1);
            left_in = left_dec;
            pend_in = pend_dec;
            if (pend_dec == '0) begin
               phase_in = (left_dec != '0) ? prdc_pkg::PH_HEADER : prdc_pkg::PH_DRAIN;
            end else if (left_dec == '0) begin
               err_in   = last ? prdc_pkg::ST_END_COPY : prdc_pkg::ST_COPY_FULL;
               pend_in  = '0;
               phase_in = prdc_pkg::PH_DRAIN;
            end else if (last) begin
               err_in = prdc_pkg::ST_END_COPY;
            end
         end
         default: begin
            // output full: count what is left over, saturating
            if (cur_lo != '1) lo_in = cur_lo + 1'b1;
         end
      endcase
      if (last) begin
         phase_in = prdc_pkg::PH_HEADER;
         pend_in  = '0;
      end
   end

   // queue entry
   always_comb begin
      logic [prdc_pkg::REP_W-1:0] rep;
      rep = '0;
      if (left_in != '0) rep = prdc_pkg::REP_W'(0) - {2'b00, left_in};
      // a lone trailing byte with a clean row is tolerated
      if (lo_in != '0 && (err_in != prdc_pkg::ST_OK || lo_in != prdc_pkg::LO_W'(1))) begin
         rep = {1'b0, lo_in};
      end
      push_data.has_run     = has_run;
      push_data.run_byte    = b;
      push_data.run_count   = run_cnt;
      push_data.has_final   = last;
      push_data.final_count = left_in;
      push_data.status      = err_in;
      push_data.report      = rep;
      push                  = accept && (has_run || last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_open_ff <= 1'b0;
         phase_ff    <= prdc_pkg::PH_HEADER;
         pend_ff     <= '0;
         left_ff     <= '0;
         lo_ff       <= '0;
         err_ff      <= prdc_pkg::ST_OK;
      end else if (accept) begin
         row_open_ff <= row_open_in;
         phase_ff    <= phase_in;
         pend_ff     <= pend_in;
         left_ff     <= left_in;
         lo_ff       <= lo_in;
         err_ff      <= err_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/prdc_queue.sv */
// Short queue of decoded entries between front and back.
`timescale 1ns / 1ps
`default_nettype none
module prdc_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire prdc_pkg::prdc_entry_type push_data,
   input  wire logic                     pop,
   output      logic                     full,
   output      logic                     empty,
   output      prdc_pkg::prdc_entry_type head
);

   prdc_pkg::prdc_entry_type          mem_ff [prdc_pkg::QDEPTH];
   logic [prdc_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [prdc_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [prdc_pkg::QCNT_W-1:0]       cnt_ff, cnt_in;

   assign full  = (cnt_ff == prdc_pkg::QCNT_W'(prdc_pkg::QDEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule
`default_nettype wire

/* rtl/prdc_back.sv */
// Back end: splits queue entries into result items and holds the output register.
`timescale 1ns / 1ps
`default_nettype none
module prdc_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     empty,
   input  wire prdc_pkg::prdc_entry_type head,
   output      logic                     pop,
   prdc_rsp_if.source                    rsp
);

   logic                          valid_ff, valid_in;
   logic                          half_ff, half_in;
   logic [7:0]                    byte_ff, byte_in;
   logic [prdc_pkg::ROW_W-1:0]    count_ff, count_in;
   logic                          fin_ff, fin_in;
   prdc_pkg::prdc_status_type     status_ff, status_in;
   logic [prdc_pkg::REP_W-1:0]    report_ff, report_in;

   logic load;
   logic emit_run;

   assign load     = !empty && (!valid_ff || rsp.ready);
   // half_ff: the run of the head entry went out, its closing item has not
   assign emit_run = head.has_run && !half_ff;
   assign pop      = load && (!emit_run || !head.has_final);

   always_comb begin
      valid_in  = load ? 1'b1 : (valid_ff && !rsp.ready);
      half_in   = load ? (emit_run && head.has_final) : half_ff;
      byte_in   = emit_run ? head.run_byte : 8'd0;
      count_in  = emit_run ? head.run_count : head.final_count;
      fin_in    = !emit_run;
      status_in = emit_run ? prdc_pkg::ST_OK : head.status;
      report_in = emit_run ? '0 : head.report;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         half_ff  <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= byte_in;
         count_ff  <= count_in;
         fin_ff    <= fin_in;
         status_ff <= status_in;
         report_ff <= report_in;
      end
   end

   assign rsp.valid     = valid_ff;
   assign rsp.out_byte  = byte_ff;
   assign rsp.run_count = count_ff;
   assign rsp.is_final  = fin_ff;
   assign rsp.status    = status_ff;
   assign rsp.report    = $signed(report_ff);

endmodule
`default_nettype wire

/* rtl/packbits_row_decoder.sv */
// Top level of the PackBits row decoder: register port, front, queue and back.
//
//  channel   dir  handshake          payload
//  req_bus   in   valid/ready        packed_byte, row_end
//  rsp_bus   out  valid/ready        out_byte, run_count, is_final, status, report
//  csr_*     in   APB, pready high   row_length at byte address 0
//
// One request a cycle unless the queue is full; each updates small counters in the front.
// A request gives zero, one or two result items; the back sends one item a cycle while
// rsp_bus is ready, so a run on the row's last byte gives a run item and a closing item.
// A 4-entry queue between front and back; the front stalls only when it is full.
// Synchronous reset clears control state; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module packbits_row_decoder #(
   parameter int unsigned MAX_ROW = 30000
) (
   input  wire logic        clock,
   input  wire logic        reset,
   prdc_req_if.sink         req_bus,
   prdc_rsp_if.source       rsp_bus,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);

   logic [prdc_pkg::ROW_W-1:0] row_len_ff, row_len_in;
   logic                       csr_wr;
   prdc_pkg::prdc_reg_type     csr_reg;
   logic [prdc_pkg::ROW_W-1:0] wr_val;

   logic                       push;
   logic                       pop;
   logic                       q_full;
   logic                       q_empty;
   prdc_pkg::prdc_entry_type   push_data;
   prdc_pkg::prdc_entry_type   head;

   assign csr_pready = 1'b1;
   assign csr_reg    = prdc_pkg::prdc_reg_type'(csr_paddr[2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign wr_val     = csr_pwdata[prdc_pkg::ROW_W-1:0];

   always_comb begin
      row_len_in = row_len_ff;
      if (csr_wr && csr_reg == prdc_pkg::REG_ROW_LENGTH) begin
         if ({2'b00, wr_val} > 17'(MAX_ROW)) begin
            row_len_in = prdc_pkg::ROW_W'(MAX_ROW);
         end else begin
            row_len_in = wr_val;
         end
      end
   end

   always_comb begin
      case (csr_reg)
         prdc_pkg::REG_ROW_LENGTH: csr_prdata = {17'd0, row_len_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_len_ff <= prdc_pkg::ROW_W'(1);
      end else begin
         row_len_ff <= row_len_in;
      end
   end

   prdc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .row_len   (row_len_ff),
      .q_full    (q_full),
      .push      (push),
      .push_data (push_data)
   );

   prdc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (head)
   );

   prdc_back u_back (
      .clock (clock),
      .reset (reset),
      .empty (q_empty),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_bus)
   );

endmodule
`default_nettype wire
